// ===== rtl/occ_pkg.sv =====
// Shared types and constants for the odd cycle violation check.
// No dependencies; every other file depends on this package.
package occ_pkg;

	localparam int VALUE_W = 17;
	localparam int SUM_W   = 24;
	localparam int COUNT_W = 9;
	localparam int INDEX_W = 8;
	localparam int SMALL_W = 16;
	localparam int TOL_W   = 10;
	localparam int KIND_W  = 2;

	localparam logic [VALUE_W-1:0] ONE_Q   = 17'd65536;
	localparam logic [VALUE_W-1:0] HALF_Q  = 17'd32768;
	localparam logic [SUM_W-1:0]   SUM_MAX = 24'hFF_FFFF;

	typedef enum logic [KIND_W-1:0] {
		MOVE_NONE = 2'd0,
		MOVE_OUT  = 2'd1,
		MOVE_IN   = 2'd2
	} move_kind_t;

	// cycle state handed from the accumulator to the final check
	typedef struct packed {
		logic [SUM_W-1:0]   sum;
		logic [COUNT_W-1:0] count;
		logic [SMALL_W-1:0] lsmall;
		logic [INDEX_W-1:0] lsmall_idx;
		logic [VALUE_W-1:0] slarge;
		logic [INDEX_W-1:0] slarge_idx;
	} occ_snap_t;

endpackage

// ===== rtl/occ_in_if.sv =====
// Input channel: one Q1.16 value per word plus end-of-cycle mark.
// Depends on occ_pkg for field widths.
interface occ_in_if;
	logic                         valid;
	logic                         ready;
	logic [occ_pkg::VALUE_W-1:0]  value;
	logic                         last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== rtl/occ_out_if.sv =====
// Result channel: one word per cycle, carrying the violation verdict.
// Depends on occ_pkg for field widths.
interface occ_out_if;
	logic                         valid;
	logic                         ready;
	logic                         violated;
	logic [occ_pkg::VALUE_W-1:0]  abs_violation;
	logic [occ_pkg::COUNT_W-1:0]  odd_count;
	logic [occ_pkg::KIND_W-1:0]   move_kind;
	logic [occ_pkg::INDEX_W-1:0]  moved_index;

	modport source (output valid, output violated, output abs_violation, output odd_count,
		output move_kind, output moved_index, input ready);
	modport sink   (input valid, input violated, input abs_violation, input odd_count,
		input move_kind, input moved_index, output ready);
endinterface

// ===== rtl/odd_cycle_violation_check.sv =====
// Odd cycle violation check, top level: config register, accumulator, final check.
// Depends on occ_pkg, occ_in_if, occ_out_if, occ_accum and occ_final.
//
// Usage:
//   item   - one word per edge variable: value (unsigned Q1.16, 65536 = 1.0)
//            and last, which closes the cycle.
//   result - one word per cycle, sent after the word with last set.
//   cfg_we / cfg_wdata - write the 10-bit tolerance; only while idle.
// Throughput: one item word per cycle, sustained while result is not held off;
//   cycles may follow each other with no gap.
// Path: a closing word is accepted into the input register, then passes the
//   closing-state register and then the result register before it appears
//   on result.
// Reset: arst_n clears all valids, the cycle accumulators and tolerance.
// Stall: when result is held off, the result register and the closing-state
//   register fill; non-closing words keep being accepted until a closing word
//   sits in the input register with both of them full, then item.ready drops.
// Positions saturate at min(MAX_ELEMENTS-1, 255).
module odd_cycle_violation_check #(
	parameter int MAX_ELEMENTS = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [occ_pkg::TOL_W-1:0]  cfg_wdata,
	occ_in_if.sink                     item,
	occ_out_if.source                  result
);
	import occ_pkg::*;

	logic [TOL_W-1:0] tolerance_q;
	logic             snap_valid;
	logic             snap_ready;
	occ_snap_t        snap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= '0;
		end else if (cfg_we) begin
			tolerance_q <= cfg_wdata;
		end
	end

	occ_accum #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap)
	);

	occ_final u_final (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap),
		.tolerance  (tolerance_q),
		.result     (result)
	);

	// a violation always leaves an odd subset
	a_viol_odd: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.violated |-> result.odd_count[0])
		else $error("violation reported with even subset");

	a_viol_amount: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.violated |-> result.abs_violation != '0)
		else $error("violation reported with zero amount");

	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.violated |->
			result.abs_violation == '0 && result.move_kind == MOVE_NONE
			&& result.moved_index == '0)
		else $error("non-violated result carries move data");

	a_kind_index: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.move_kind == MOVE_NONE |-> result.moved_index == '0)
		else $error("moved index set without a move");

endmodule

// ===== rtl/occ_accum.sv =====
// Input register and per-cycle accumulators (distance sum, large count, extremes).
// Depends on occ_pkg and occ_in_if; hands the closing state to occ_final.
module occ_accum #(
	parameter int MAX_ELEMENTS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	occ_in_if.sink            item,
	output logic              snap_valid,
	input  logic              snap_ready,
	output occ_pkg::occ_snap_t snap
);
	import occ_pkg::*;

	localparam int TOP_INDEX = (MAX_ELEMENTS - 1 > 255) ? 255 : MAX_ELEMENTS - 1;

	logic               s1_v_q;
	logic [VALUE_W-1:0] value_s1;
	logic               last_s1;
	logic               s1_go;
	logic               take;

	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] count_q;
	logic [INDEX_W-1:0] pos_q;
	logic [SMALL_W-1:0] ls_q;
	logic [INDEX_W-1:0] ls_idx_q;
	logic [VALUE_W-1:0] sl_q;
	logic [INDEX_W-1:0] sl_idx_q;

	logic [VALUE_W-1:0] v;
	logic               is_large;
	logic [VALUE_W-1:0] delta;
	logic [SUM_W:0]     sum_wide;
	occ_snap_t          nx;
	logic [INDEX_W-1:0] pos_nx;

	assign s1_go      = s1_v_q && (!last_s1 || snap_ready);
	assign item.ready = !s1_v_q || s1_go;
	assign take       = item.valid && item.ready;
	assign snap_valid = s1_v_q && last_s1;
	assign snap       = nx;

	always_comb begin
		v        = (value_s1 > ONE_Q) ? ONE_Q : value_s1;
		is_large = (v >= HALF_Q);
		delta    = is_large ? (ONE_Q - v) : v;
		sum_wide = {1'b0, sum_q} + (SUM_W+1)'(delta);
		nx.sum   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
		nx.count = count_q + COUNT_W'(is_large);
		nx.lsmall     = ls_q;
		nx.lsmall_idx = ls_idx_q;
		nx.slarge     = sl_q;
		nx.slarge_idx = sl_idx_q;
		if (!is_large && (ls_q < v[SMALL_W-1:0])) begin
			nx.lsmall     = v[SMALL_W-1:0];
			nx.lsmall_idx = pos_q;
		end
		if (is_large && (sl_q > v)) begin
			nx.slarge     = v;
			nx.slarge_idx = pos_q;
		end
		pos_nx = (pos_q < INDEX_W'(TOP_INDEX)) ? pos_q + 1'b1 : pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (take) begin
			s1_v_q <= 1'b1;
		end else if (s1_go) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			value_s1 <= item.value;
			last_s1  <= item.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			count_q  <= '0;
			pos_q    <= '0;
			ls_q     <= '0;
			ls_idx_q <= '0;
			sl_q     <= ONE_Q;
			sl_idx_q <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				sum_q    <= '0;
				count_q  <= '0;
				pos_q    <= '0;
				ls_q     <= '0;
				ls_idx_q <= '0;
				sl_q     <= ONE_Q;
				sl_idx_q <= '0;
			end else begin
				sum_q    <= nx.sum;
				count_q  <= nx.count;
				pos_q    <= pos_nx;
				ls_q     <= nx.lsmall;
				ls_idx_q <= nx.lsmall_idx;
				sl_q     <= nx.slarge;
				sl_idx_q <= nx.slarge_idx;
			end
		end
	end

endmodule

// ===== rtl/occ_final.sv =====
// Closing-state register, odd-subset violation test and result register.
// Depends on occ_pkg and occ_out_if; fed by occ_accum.
module occ_final (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         snap_valid,
	output logic                         snap_ready,
	input  occ_pkg::occ_snap_t           snap,
	input  logic [occ_pkg::TOL_W-1:0]    tolerance,
	occ_out_if.source                    result
);
	import occ_pkg::*;

	logic          s2_v_q;
	occ_snap_t     snap_s2;
	logic          out_v_q;
	logic          out_free;
	logic          s2_go;

	logic [VALUE_W-1:0] limit;
	logic [VALUE_W:0]   alt_out;
	logic [VALUE_W:0]   alt_in;
	logic [VALUE_W-1:0] low_sum;
	logic [VALUE_W-1:0] fin_sum;
	logic               viol;
	logic [COUNT_W-1:0] fin_count;
	move_kind_t         kind;
	logic [INDEX_W-1:0] midx;

	logic               viol_q;
	logic [VALUE_W-1:0] abs_q;
	logic [COUNT_W-1:0] count_q;
	move_kind_t         kind_q;
	logic [INDEX_W-1:0] midx_q;

	assign out_free   = !out_v_q || result.ready;
	assign s2_go      = s2_v_q && out_free;
	assign snap_ready = !s2_v_q || out_free;

	always_comb begin
		limit     = ONE_Q - VALUE_W'(tolerance);
		low_sum   = snap_s2.sum[VALUE_W-1:0];
		alt_out   = (VALUE_W+1)'(low_sum) + {snap_s2.slarge, 1'b0} - (VALUE_W+1)'(ONE_Q);
		alt_in    = (VALUE_W+1)'(low_sum) + (VALUE_W+1)'(ONE_Q)
			- {1'b0, snap_s2.lsmall, 1'b0};
		viol      = 1'b0;
		fin_sum   = low_sum;
		fin_count = snap_s2.count;
		kind      = MOVE_NONE;
		midx      = '0;
		if (snap_s2.sum < SUM_W'(limit)) begin
			viol = snap_s2.count[0];
			if (!viol && (snap_s2.slarge < limit) && (alt_out < {1'b0, limit})) begin
				viol      = 1'b1;
				fin_sum   = alt_out[VALUE_W-1:0];
				fin_count = snap_s2.count - 1'b1;
				kind      = MOVE_OUT;
				midx      = snap_s2.slarge_idx;
			end
			if (!viol && (snap_s2.lsmall > SMALL_W'(tolerance))
				&& (alt_in < {1'b0, limit})) begin
				viol      = 1'b1;
				fin_sum   = alt_in[VALUE_W-1:0];
				fin_count = snap_s2.count + 1'b1;
				kind      = MOVE_IN;
				midx      = snap_s2.lsmall_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (snap_valid && snap_ready) begin
				s2_v_q <= 1'b1;
			end else if (s2_go) begin
				s2_v_q <= 1'b0;
			end
			if (s2_go) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && snap_ready) begin
			snap_s2 <= snap;
		end
		if (s2_go) begin
			viol_q  <= viol;
			abs_q   <= viol ? (ONE_Q - fin_sum) : '0;
			count_q <= fin_count;
			kind_q  <= kind;
			midx_q  <= midx;
		end
	end

	assign result.valid         = out_v_q;
	assign result.violated      = viol_q;
	assign result.abs_violation = abs_q;
	assign result.odd_count     = count_q;
	assign result.move_kind     = kind_q;
	assign result.moved_index   = midx_q;

endmodule

// ===== dv/tb_top.sv =====
// Testbench for odd_cycle_violation_check: random and directed cycles of Q1.16 values,
// a built-in predictor of the closing verdict, and random stalls on both channels.
// Depends on occ_pkg, occ_in_if, occ_out_if and the odd_cycle_violation_check RTL.
module tb_top;
	import occ_pkg::*;

	localparam int MAX_EL      = 256;
	localparam int TOP_POS     = (MAX_EL - 1 > 255) ? 255 : MAX_EL - 1;
	localparam int PAUSE_MAX   = 9;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 8;
	localparam int WAIT_BOUND  = 2000;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} word_t;

	typedef struct packed {
		logic               violated;
		logic [VALUE_W-1:0] abs_violation;
		logic [COUNT_W-1:0] odd_count;
		move_kind_t         move_kind;
		logic [INDEX_W-1:0] moved_index;
	} verdict_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [TOL_W-1:0] cfg_wdata = '0;

	occ_in_if  item_ch ();
	occ_out_if res_ch ();

	odd_cycle_violation_check #(.MAX_ELEMENTS(MAX_EL)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (res_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("%0t: timeout", $time);
		$display("** odd_cycle_violation_check: FAILED **");
		$finish;
	end

	word_t       pending [$];
	verdict_t    verdict_q [$];
	word_t       cur_word;
	verdict_t    got, want;
	bit          in_busy = 0, in_burst = 0, send_burst = 0;
	bit          out_burst = 0, hold_req = 0;
	int unsigned in_gap = 0, out_wait = 0, hold_left = 0;
	int          errors = 0, words_sent = 0, closed = 0, stall_cycles = 0, tol_writes = 0;
	int          direct_hits = 0, out_hits = 0, in_hits = 0;

	// predictor state of the open cycle
	logic [TOL_W-1:0]   tol_cfg = '0;
	int unsigned        cyc_sum = 0;
	logic [COUNT_W-1:0] cyc_large = '0;
	logic [INDEX_W-1:0] cyc_pos = '0;
	logic [SMALL_W-1:0] top_small = '0;
	logic [INDEX_W-1:0] top_small_pos = '0;
	logic [VALUE_W-1:0] low_large = ONE_Q;
	logic [INDEX_W-1:0] low_large_pos = '0;

	function automatic void absorb_value(input word_t w);
		logic [VALUE_W-1:0] v;
		int unsigned        part, sum, lim, alt;
		logic [COUNT_W-1:0] cnt;
		verdict_t           vd;
		v = (w.value > ONE_Q) ? ONE_Q : w.value;
		if (v < HALF_Q) begin
			part = v;
			if (top_small < v) begin
				top_small = v[SMALL_W-1:0];
				top_small_pos = cyc_pos;
			end
		end else begin
			part = ONE_Q - v;
			cyc_large = cyc_large + 1'b1;
			if (low_large > v) begin
				low_large = v;
				low_large_pos = cyc_pos;
			end
		end
		cyc_sum = cyc_sum + part;
		if (cyc_sum > SUM_MAX)
			cyc_sum = SUM_MAX;
		if (cyc_pos < TOP_POS)
			cyc_pos = cyc_pos + 1'b1;
		if (!w.last)
			return;

		sum = cyc_sum;
		cnt = cyc_large;
		lim = ONE_Q - tol_cfg;
		vd = '0;
		vd.move_kind = MOVE_NONE;
		if (sum < lim) begin
			vd.violated = cnt[0];
			if (!vd.violated && low_large < lim) begin
				alt = sum + 2 * low_large - ONE_Q;
				if (alt < lim) begin
					vd.violated = 1'b1;
					sum = alt;
					cnt = cnt - 1'b1;
					vd.move_kind = MOVE_OUT;
					vd.moved_index = low_large_pos;
				end
			end
			if (!vd.violated && top_small > tol_cfg) begin
				alt = sum + ONE_Q - 2 * top_small;
				if (alt < lim) begin
					vd.violated = 1'b1;
					sum = alt;
					cnt = cnt + 1'b1;
					vd.move_kind = MOVE_IN;
					vd.moved_index = top_small_pos;
				end
			end
		end
		if (vd.violated)
			vd.abs_violation = VALUE_W'(ONE_Q - sum);
		vd.odd_count = cnt;
		verdict_q.push_back(vd);

		cyc_sum = 0;
		cyc_large = '0;
		cyc_pos = '0;
		top_small = '0;
		top_small_pos = '0;
		low_large = ONE_Q;
		low_large_pos = '0;
	endfunction

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && !item_ch.ready)
				stall_cycles++;
			if (item_ch.valid && item_ch.ready) begin
				absorb_value(cur_word);
				words_sent++;
				in_busy = 0;
				in_gap = (send_burst || in_burst) ? 0 : $urandom_range(0, PAUSE_MAX);
				if ($urandom_range(0, 29) == 0)
					in_burst = !in_burst;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && !in_busy) begin
			if (in_gap > 0) begin
				in_gap--;
				item_ch.valid <= 1'b0;
			end else if (pending.size() > 0) begin
				cur_word = pending.pop_front();
				item_ch.valid <= 1'b1;
				item_ch.value <= cur_word.value;
				item_ch.last <= cur_word.last;
				in_busy = 1;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.violated = res_ch.violated;
			got.abs_violation = res_ch.abs_violation;
			got.odd_count = res_ch.odd_count;
			got.move_kind = move_kind_t'(res_ch.move_kind);
			got.moved_index = res_ch.moved_index;
			if (verdict_q.size() == 0) begin
				$display("%0t: unexpected result word, actual viol=%0b abs=%0d count=%0d kind=%0d idx=%0d",
					$time, got.violated, got.abs_violation, got.odd_count, got.move_kind,
					got.moved_index);
				errors++;
			end else begin
				want = verdict_q.pop_front();
				closed++;
				if (want.violated) begin
					case (want.move_kind)
						MOVE_NONE: direct_hits++;
						MOVE_OUT:  out_hits++;
						MOVE_IN:   in_hits++;
						default:   ;
					endcase
				end
				if (got !== want) begin
					$display("%0t: mismatch, expected viol=%0b abs=%0d count=%0d kind=%0d idx=%0d",
						$time, want.violated, want.abs_violation, want.odd_count, want.move_kind,
						want.moved_index);
					$display("%0t:           actual viol=%0b abs=%0d count=%0d kind=%0d idx=%0d",
						$time, got.violated, got.abs_violation, got.odd_count, got.move_kind,
						got.moved_index);
					errors++;
				end
			end
			out_wait = out_burst ? 0 : $urandom_range(0, PAUSE_MAX);
			if ($urandom_range(0, 19) == 0)
				out_burst = !out_burst;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (out_wait > 0) begin
				out_wait--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	task automatic push_word(input int unsigned v, input bit l);
		word_t w;
		w.value = v[VALUE_W-1:0];
		w.last = l;
		pending.push_back(w);
	endtask

	task automatic add_cycle(input int len);
		int unsigned dmax, pick, v;
		bit          wild;
		dmax = $urandom_range(1, 131072 / len);
		if (dmax > 32767)
			dmax = 32767;
		wild = ($urandom_range(0, 7) == 0);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 19);
			if (wild || pick == 1)
				v = $urandom_range(0, 131071);
			else if (pick == 0)
				v = $urandom_range(65537, 131071);
			else if (pick == 2)
				v = $urandom_range(32700, 32840);
			else if (pick < 12)
				v = $urandom_range(0, dmax);
			else
				v = ONE_Q - $urandom_range(0, dmax);
			push_word(v, i == len - 1);
		end
	endtask

	task automatic add_random(input int n);
		int done, len, r;
		done = 0;
		while (done < n) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				len = $urandom_range(1, 2);
			else if (r == 1)
				len = $urandom_range(20, 60);
			else
				len = $urandom_range(3, 10);
			add_cycle(len);
			done += len;
		end
	endtask

	task automatic settle();
		int spin;
		spin = 0;
		while (pending.size() != 0 || in_busy)
			@(negedge clk);
		while (verdict_q.size() != 0 && spin < WAIT_BOUND) begin
			@(negedge clk);
			spin++;
		end
		if (verdict_q.size() != 0) begin
			$display("%0t: %0d expected result words never arrived", $time, verdict_q.size());
			errors++;
			verdict_q.delete();
		end
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic set_tolerance(input logic [TOL_W-1:0] t);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= t;
		@(negedge clk);
		cfg_we <= 1'b0;
		tol_cfg = t;
		tol_writes++;
	endtask

	initial begin
		int plan [6];
		item_ch.valid = 1'b0;
		item_ch.value = '0;
		item_ch.last = 1'b0;
		res_ch.ready = 1'b0;
		plan = '{1023, 0, 512, -1, 1, -1};
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed: single words, above one, half line, both moves, no violation
		push_word(0, 1);
		push_word(65536, 1);
		push_word(131071, 1);
		push_word(32768, 1);
		push_word(32767, 1);
		push_word(65536, 0); push_word(60000, 0); push_word(0, 1);
		push_word(32768, 0); push_word(32768, 0); push_word(32767, 1);
		push_word(100, 0); push_word(65536, 0); push_word(65000, 0); push_word(200, 1);
		push_word(1, 0); push_word(65535, 0); push_word(65535, 1);
		push_word(30000, 0); push_word(65536, 0); push_word(65536, 1);
		settle();

		foreach (plan[i]) begin
			set_tolerance(TOL_W'(plan[i] < 0 ? $urandom_range(0, 1023) : plan[i]));
			add_random(22);
			settle();
		end

		// long result stall while words keep coming
		hold_req = 1;
		send_burst = 1;
		for (int i = 0; i < 40; i++)
			add_cycle($urandom_range(1, 3));
		settle();
		send_burst = 0;

		// long cycle: positions saturate, then a move out at the top index
		for (int i = 0; i < 270; i++)
			push_word((i == 265) ? 40000 : (i == 268) ? 65536 : 0, i == 269);
		settle();

		$display("%0d words sent, %0d cycles closed under %0d tolerance settings",
			words_sent, closed, tol_writes);
		$display("violations: %0d direct, %0d moved out, %0d moved in; %0d input stall cycles",
			direct_hits, out_hits, in_hits, stall_cycles);
		if (errors == 0)
			$display("** odd_cycle_violation_check: PASSED **");
		else
			$display("** odd_cycle_violation_check: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/occ_pkg.sv
rtl/occ_in_if.sv
rtl/occ_out_if.sv
rtl/occ_accum.sv
rtl/occ_final.sv
rtl/odd_cycle_violation_check.sv
dv/tb_top.sv
